// ===== hw/rtl/wsht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test package
// Shared types and constants for the hit-test block.
// ----------------------------------------------------------------------------
package wsht_pkg;

   localparam int MAX_WINDOWS_DEF = 16;
   localparam int IDX_W           = 5;
   localparam int RANK_W          = 5;
   localparam int COORD_W         = 16;
   localparam int RECT_W          = 4 * COORD_W;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [IDX_W:0]     cnt_type;
   typedef logic [COORD_W-1:0] coord_type;

   localparam idx_type COUNT_RESET = idx_type'(16);

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_CLICK = 1'b1;

   typedef struct packed {
      logic      kind;
      idx_type   window_index;
      coord_type rect_left;
      coord_type rect_top;
      coord_type rect_right;
      coord_type rect_bottom;
      coord_type click_x;
      coord_type click_y;
   } req_type;

   typedef struct packed {
      logic    hit;
      idx_type hit_window;
   } rsp_type;

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } rect_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/wsht_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wsht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/window_stack_hit_test_top.sv =====
// Load items give no result; the next item can be taken in the cycle after.
// A click reads both RAMs in one pass to find the topmost hit; on a hit a second
// read-modify-write pass over the rank RAM moves the windows above it down one rank
// and sets its rank to one. A miss skips the second pass.
// One item is worked at a time. Synchronous active-high reset clears all ranks
// (per-entry valid bits), sets the window count to 16 and empties the output.
`default_nettype none
// ----------------------------------------------------------------------------
// Window stack hit test
// Keeps window rectangles and stacking ranks in RAM, answers clicks with the
// topmost window hit and brings that window to the front.
// ----------------------------------------------------------------------------
module window_stack_hit_test_top #(
   parameter int MAX_WINDOWS = wsht_pkg::MAX_WINDOWS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire wsht_pkg::req_type req_item,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output wsht_pkg::rsp_type      rsp_item,
   input  wire logic              csr_we,
   input  wire wsht_pkg::idx_type csr_wdata
);

   localparam int AW = $clog2(MAX_WINDOWS);
   typedef logic [AW-1:0] addr_type;

   wsht_pkg::state_type state_ff, state_in;
   wsht_pkg::idx_type   count_ff;
   wsht_pkg::cnt_type   issue_ff, issue_in;
   logic                pend_ff, pend_in;
   wsht_pkg::idx_type   pend_idx_ff, pend_idx_in;
   wsht_pkg::idx_type   best_ff, best_in;
   wsht_pkg::rank_type  best_rank_ff, best_rank_in;
   logic [MAX_WINDOWS-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wsht_pkg::rsp_type   rsp_item_ff, rsp_item_in;
   wsht_pkg::coord_type click_x_ff, click_y_ff;

   wsht_pkg::idx_type   eff_count;
   logic                issuing;
   addr_type            rd_addr, pend_addr, load_addr;
   logic                rd_en;
   logic                rank_we, rect_we;
   addr_type            rank_waddr;
   wsht_pkg::rank_type  rank_wdata, rank_rd, rank_eff, rank_new;
   logic [wsht_pkg::RECT_W-1:0] rect_rd;
   wsht_pkg::rect_type  rect;
   wsht_pkg::rect_type  load_rect;
   logic                holds, candidate, load_ok;

   // Count above the table acts as the table size
   always_comb begin
      if (32'(count_ff) > MAX_WINDOWS) begin
         eff_count = wsht_pkg::idx_type'(MAX_WINDOWS);
      end else begin
         eff_count = count_ff;
      end
   end

   assign issuing   = (issue_ff <= {1'b0, eff_count});
   assign rd_addr   = addr_type'(wsht_pkg::idx_type'(issue_ff[wsht_pkg::IDX_W-1:0] - 1'b1));
   assign pend_addr = addr_type'(wsht_pkg::idx_type'(pend_idx_ff - 1'b1));
   assign load_addr = addr_type'(wsht_pkg::idx_type'(req_item.window_index - 1'b1));
   assign load_ok   = (req_item.window_index != '0) && (req_item.window_index <= eff_count);

   assign load_rect = '{left:   req_item.rect_left,
                        top:    req_item.rect_top,
                        right:  req_item.rect_right,
                        bottom: req_item.rect_bottom};

   // Entries never loaded read as rank zero
   assign rank_eff = valid_ff[pend_addr] ? rank_rd : '0;
   assign rect     = wsht_pkg::rect_type'(rect_rd);
   assign holds    = (click_x_ff >= rect.left) && (click_x_ff <= rect.right) &&
                     (click_y_ff >= rect.top)  && (click_y_ff <= rect.bottom);
   assign candidate = (rank_eff != '0) && (rank_eff <= eff_count) && holds &&
                      ((best_ff == '0) || (rank_eff < best_rank_ff));

   always_comb begin
      if (pend_idx_ff == best_ff) begin
         rank_new = wsht_pkg::rank_type'(1);
      end else if ((rank_eff != '0) && (rank_eff < best_rank_ff)) begin
         rank_new = wsht_pkg::rank_type'(rank_eff + 1'b1);
      end else begin
         rank_new = rank_eff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      best_in      = best_ff;
      best_rank_in = best_rank_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rank_we      = 1'b0;
      rect_we      = 1'b0;
      rank_waddr   = load_addr;
      rank_wdata   = wsht_pkg::rank_type'(eff_count - req_item.window_index + 1'b1);

      unique case (state_ff)
         wsht_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_item.kind == wsht_pkg::KIND_LOAD) begin
                  if (load_ok) begin
                     rank_we             = 1'b1;
                     rect_we             = 1'b1;
                     valid_in[load_addr] = 1'b1;
                  end
               end else begin
                  state_in     = wsht_pkg::ST_SCAN;
                  issue_in     = wsht_pkg::cnt_type'(1);
                  best_in      = '0;
                  best_rank_in = '0;
               end
            end
         end
         wsht_pkg::ST_SCAN: begin
            if (issuing) begin
               rd_en       = 1'b1;
               issue_in    = wsht_pkg::cnt_type'(issue_ff + 1'b1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[wsht_pkg::IDX_W-1:0];
            end
            if (pend_ff && candidate) begin
               best_in      = pend_idx_ff;
               best_rank_in = rank_eff;
            end
            if (!issuing && !pend_ff) begin
               issue_in = wsht_pkg::cnt_type'(1);
               state_in = (best_ff == '0) ? wsht_pkg::ST_RESP : wsht_pkg::ST_UPDATE;
            end
         end
         wsht_pkg::ST_UPDATE: begin
            if (issuing) begin
               rd_en       = 1'b1;
               issue_in    = wsht_pkg::cnt_type'(issue_ff + 1'b1);
               pend_in     = 1'b1;
               pend_idx_in = issue_ff[wsht_pkg::IDX_W-1:0];
            end
            // Write back the entry read last cycle; the next read is a different entry
            if (pend_ff && valid_ff[pend_addr]) begin
               rank_we    = 1'b1;
               rank_waddr = pend_addr;
               rank_wdata = rank_new;
            end
            if (!issuing && !pend_ff) begin
               state_in = wsht_pkg::ST_RESP;
            end
         end
         wsht_pkg::ST_RESP: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{hit: (best_ff != '0), hit_window: best_ff};
               state_in     = wsht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsht_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsht_pkg::ST_IDLE;
         count_ff     <= wsht_pkg::COUNT_RESET;
         issue_ff     <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff  <= pend_idx_in;
      best_ff      <= best_in;
      best_rank_ff <= best_rank_in;
      rsp_item_ff  <= rsp_item_in;
      if (req_valid && req_ready) begin
         click_x_ff <= req_item.click_x;
         click_y_ff <= req_item.click_y;
      end
   end

   wsht_ram #(
      .WIDTH (wsht_pkg::RECT_W),
      .DEPTH (MAX_WINDOWS)
   ) u_rect_ram (
      .clock   (clock),
      .wr_en   (rect_we),
      .wr_addr (load_addr),
      .wr_data (load_rect),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rect_rd)
   );

   wsht_ram #(
      .WIDTH (wsht_pkg::RANK_W),
      .DEPTH (MAX_WINDOWS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (rank_waddr),
      .wr_data (rank_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rank_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_hit_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.hit |-> (rsp_item_ff.hit_window != '0))
      else $error("hit reported with window zero");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_item_ff.hit |-> (rsp_item_ff.hit_window == '0))
      else $error("miss reported with nonzero window");

   a_click_busy : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_item.kind == wsht_pkg::KIND_CLICK) |=> !req_ready)
      else $error("new item accepted while a click is in progress");

   a_idle_no_pend : assert property (@(posedge clock) disable iff (reset)
      (state_ff == wsht_pkg::ST_IDLE) |-> !pend_ff)
      else $error("RAM read pending while idle");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_window_stack_hit_test_top.sv =====
// ----------------------------------------------------------------------------
// Window stack hit test bench
// Loads window rectangles and clicks into the block through its handshake,
// predicts every click result from a private copy of the window table and
// ranks, and compares each result in order. A short directed table comes
// first, then randomized phases at several window counts, with random gaps
// and stalls on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_window_stack_hit_test_top;
   import wsht_pkg::*;

   localparam int MAX_WIN       = MAX_WINDOWS_DEF;
   localparam int SETTLE_CYCLES = 2 * MAX_WIN + 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASES        = 16;
   localparam int PHASE_ITEMS   = 100;

   typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_type;

   typedef struct {
      row_kind_type op;
      req_type      item;
      bit           fixed;
      rsp_type      fixed_rsp;
      idx_type      count;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_item;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_item;
   logic    csr_we;
   idx_type csr_wdata;

   // Typed-in expectation travels alongside the item it belongs to
   bit      req_fixed;
   rsp_type req_fixed_rsp;

   bit req_gap_on   = 1'b1;
   bit rsp_stall_on = 1'b1;
   bit hold_request = 1'b0;

   // Predicted window table
   rect_type win_rect[1:MAX_WIN];
   rank_type win_rank[1:MAX_WIN] = '{default: '0};
   idx_type  win_count = COUNT_RESET;

   rsp_type click_answers_q[$];
   int      mismatch_count = 0;
   int      quiet_cycles = 0;

   window_stack_hit_test_top #(
      .MAX_WINDOWS(MAX_WIN)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Apply one item to the predicted table; returns 1 when it yields a result
   function automatic bit step_window_stack(input req_type it, output rsp_type res);
      int n;
      int best;
      int best_rank;
      n = (int'(win_count) > MAX_WIN) ? MAX_WIN : int'(win_count);
      res = '0;
      if (it.kind == KIND_LOAD) begin
         if (it.window_index >= 1 && int'(it.window_index) <= n) begin
            win_rect[it.window_index] = '{it.rect_left, it.rect_top,
                                          it.rect_right, it.rect_bottom};
            win_rank[it.window_index] = rank_type'(n - int'(it.window_index) + 1);
         end
         return 1'b0;
      end
      best = 0;
      best_rank = 0;
      for (int t = 1; t <= n; t++) begin
         if (win_rank[t] == 0 || int'(win_rank[t]) > n)
            continue;
         if (it.click_x < win_rect[t].left || it.click_x > win_rect[t].right ||
             it.click_y < win_rect[t].top || it.click_y > win_rect[t].bottom)
            continue;
         if (best == 0 || int'(win_rank[t]) < best_rank) begin
            best = t;
            best_rank = int'(win_rank[t]);
         end
      end
      if (best == 0)
         return 1'b1;
      // bring to front: everything above it moves down one rank
      for (int t = 1; t <= n; t++) begin
         if (win_rank[t] != 0 && int'(win_rank[t]) < best_rank)
            win_rank[t] = win_rank[t] + 1'b1;
         if (t == best)
            win_rank[t] = rank_type'(1);
      end
      res.hit = 1'b1;
      res.hit_window = idx_type'(best);
      return 1'b1;
   endfunction

   function automatic dir_row_type load_row(int idx, int l, int t, int r, int b);
      dir_row_type row;
      row.op = ROW_ITEM;
      row.item = '0;
      row.fixed = 1'b0;
      row.fixed_rsp = '0;
      row.count = '0;
      row.item.kind = KIND_LOAD;
      row.item.window_index = idx_type'(idx);
      row.item.rect_left = coord_type'(l);
      row.item.rect_top = coord_type'(t);
      row.item.rect_right = coord_type'(r);
      row.item.rect_bottom = coord_type'(b);
      return row;
   endfunction

   function automatic dir_row_type click_row(int x, int y, bit fixed = 1'b0,
                                             bit hit = 1'b0, int win = 0);
      dir_row_type row;
      row.op = ROW_ITEM;
      row.item = '0;
      row.count = '0;
      row.item.kind = KIND_CLICK;
      row.item.click_x = coord_type'(x);
      row.item.click_y = coord_type'(y);
      row.fixed = fixed;
      row.fixed_rsp.hit = hit;
      row.fixed_rsp.hit_window = idx_type'(win);
      return row;
   endfunction

   function automatic dir_row_type count_row(int v);
      dir_row_type row;
      row.op = ROW_COUNT;
      row.item = '0;
      row.fixed = 1'b0;
      row.fixed_rsp = '0;
      row.count = idx_type'(v);
      return row;
   endfunction

   function automatic coord_type pick_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4, 5, 6: return coord_type'($urandom_range(0, 1023));
         default: return coord_type'($urandom());
      endcase
   endfunction

   function automatic req_type random_fill();
      req_type it;
      it.kind = 1'($urandom_range(0, 1));
      it.window_index = idx_type'($urandom_range(0, 31));
      it.rect_left = coord_type'($urandom());
      it.rect_top = coord_type'($urandom());
      it.rect_right = coord_type'($urandom());
      it.rect_bottom = coord_type'($urandom());
      it.click_x = coord_type'($urandom());
      it.click_y = coord_type'($urandom());
      return it;
   endfunction

   function automatic req_type random_load(int idx);
      req_type it;
      int lo;
      int hi;
      it = random_fill();
      it.kind = KIND_LOAD;
      it.window_index = idx_type'(idx);
      lo = int'(pick_coord());
      hi = lo + int'($urandom_range(0, 400));
      if (hi > 65535) hi = 65535;
      // now and then swap the bounds; the rectangle then holds nothing unless they are equal
      if ($urandom_range(0, 11) == 0) begin
         it.rect_left = coord_type'(hi);
         it.rect_right = coord_type'(lo);
      end else begin
         it.rect_left = coord_type'(lo);
         it.rect_right = coord_type'(hi);
      end
      lo = int'(pick_coord());
      hi = lo + int'($urandom_range(0, 400));
      if (hi > 65535) hi = 65535;
      if ($urandom_range(0, 11) == 0) begin
         it.rect_top = coord_type'(hi);
         it.rect_bottom = coord_type'(lo);
      end else begin
         it.rect_top = coord_type'(lo);
         it.rect_bottom = coord_type'(hi);
      end
      return it;
   endfunction

   function automatic req_type random_item(int n);
      req_type it;
      int t;
      if ($urandom_range(0, 99) < 45) begin
         if (n == 0 || $urandom_range(0, 9) == 0)
            return random_load(int'($urandom_range(0, 31)));
         return random_load(int'($urandom_range(1, n)));
      end
      it = random_fill();
      it.kind = KIND_CLICK;
      it.click_x = pick_coord();
      it.click_y = pick_coord();
      if (n > 0 && $urandom_range(0, 99) < 65) begin
         t = int'($urandom_range(1, n));
         // aim inside a live window to reach the hit path
         if (win_rank[t] != 0) begin
            it.click_x = coord_type'($urandom_range(int'(win_rect[t].left),
                                                    int'(win_rect[t].right)));
            it.click_y = coord_type'($urandom_range(int'(win_rect[t].top),
                                                    int'(win_rect[t].bottom)));
         end
      end
      return it;
   endfunction

   task automatic send_item(input req_type it, input bit fixed, input rsp_type fixed_rsp);
      int gap;
      gap = req_gap_on ? int'($urandom_range(0, 14)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      req_fixed <= fixed;
      req_fixed_rsp <= fixed_rsp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Called at a clock edge with the request side already idle
   task automatic set_window_count(input idx_type v);
      while (click_answers_q.size() != 0) @(posedge clock);
      // a load may still be in flight; let it land before the write
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      win_count = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type want;
      rsp_type predicted;
      bit      produces;
      if (!reset && rsp_valid && rsp_ready) begin
         if (click_answers_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected click result: hit=%0d window=%0d",
                        rsp_item.hit, rsp_item.hit_window);
         end else begin
            want = click_answers_q.pop_front();
            if (rsp_item.hit !== want.hit || rsp_item.hit_window !== want.hit_window) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("click mismatch: expected hit=%0d window=%0d, got hit=%0d window=%0d",
                           want.hit, want.hit_window, rsp_item.hit, rsp_item.hit_window);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         produces = step_window_stack(req_item, predicted);
         if (produces)
            click_answers_q.push_back(req_fixed ? req_fixed_rsp : predicted);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : receiver
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = rsp_stall_on ? int'($urandom_range(0, 14)) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin : stimulus
      dir_row_type dir_rows[$];
      idx_type     cnt;
      int          n;
      int          sent;
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      req_fixed = 1'b0;
      req_fixed_rsp = '0;
      csr_we = 1'b0;
      csr_wdata = '0;

      dir_rows.push_back(click_row(0, 0, 1'b1, 1'b0, 0));         // nothing loaded yet
      dir_rows.push_back(load_row(0, 0, 0, 10, 10));             // index zero, dropped
      dir_rows.push_back(load_row(31, 0, 0, 10, 10));            // above the count
      dir_rows.push_back(load_row(17, 0, 0, 10, 10));
      dir_rows.push_back(click_row(5, 5, 1'b1, 1'b0, 0));
      dir_rows.push_back(load_row(1, 0, 0, 65535, 65535));
      dir_rows.push_back(click_row(65535, 65535, 1'b1, 1'b1, 1));
      dir_rows.push_back(load_row(16, 100, 200, 300, 400));      // ties rank with window 1
      dir_rows.push_back(click_row(200, 300));
      dir_rows.push_back(load_row(15, 500, 500, 400, 600));      // inverted in x
      dir_rows.push_back(load_row(14, 100, 700, 300, 600));      // inverted in y
      dir_rows.push_back(click_row(450, 550));
      dir_rows.push_back(click_row(200, 650));
      dir_rows.push_back(load_row(1, 1000, 1000, 1000, 1000));
      dir_rows.push_back(click_row(300, 400));
      dir_rows.push_back(click_row(301, 400));
      dir_rows.push_back(click_row(1000, 1000));
      dir_rows.push_back(count_row(1));                          // others rank past count
      dir_rows.push_back(load_row(2, 0, 0, 65535, 65535));
      dir_rows.push_back(click_row(1000, 1000));
      dir_rows.push_back(load_row(1, 0, 0, 0, 0));
      dir_rows.push_back(click_row(0, 0));
      dir_rows.push_back(count_row(0));
      dir_rows.push_back(load_row(1, 0, 0, 65535, 65535));
      dir_rows.push_back(click_row(0, 0, 1'b1, 1'b0, 0));
      dir_rows.push_back(count_row(31));                         // clamps to the table
      dir_rows.push_back(click_row(0, 0));
      dir_rows.push_back(load_row(16, 0, 0, 65535, 65535));
      dir_rows.push_back(count_row(17));
      dir_rows.push_back(click_row(65535, 65535));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].op == ROW_COUNT) begin
            req_valid <= 1'b0;
            set_window_count(dir_rows[i].count);
         end else begin
            send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].fixed_rsp);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: cnt = idx_type'(16);
            1: cnt = idx_type'(31);
            2: cnt = idx_type'(1);
            3: cnt = idx_type'(17);
            4: cnt = idx_type'(0);
            default: cnt = ($urandom_range(0, 7) == 0) ? idx_type'($urandom_range(0, 31))
                                                       : idx_type'($urandom_range(2, 16));
         endcase
         req_valid <= 1'b0;
         set_window_count(cnt);
         n = (int'(cnt) > MAX_WIN) ? MAX_WIN : int'(cnt);
         req_gap_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         rsp_stall_on = (ph != 0) && ($urandom_range(0, 3) != 0);
         if (ph == 5) begin
            // starve the result side while requests keep coming
            req_gap_on = 1'b0;
            hold_request = 1'b1;
         end
         sent = 0;
         if (n > 0 && $urandom_range(0, 2) != 0) begin
            for (int w = 1; w <= n; w++) begin
               send_item(random_load(w), 1'b0, '0);
               sent++;
            end
         end
         while (sent < PHASE_ITEMS) begin
            send_item(random_item(n), 1'b0, '0);
            sent++;
         end
      end

      req_valid <= 1'b0;
      while (click_answers_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && click_answers_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
